// File: design/swbm_pkg.sv
package swbm_pkg;

	localparam int SOFT_RESET_TICKS = 64;
	localparam logic [15:0] SR_HALF_TICKS = 16'(SOFT_RESET_TICKS / 2);
	localparam logic [15:0] SR_FULL_TICKS = 16'(SOFT_RESET_TICKS);

	localparam logic [2:0] REQ_NONE       = 3'd0;
	localparam logic [2:0] REQ_BUS_RESET  = 3'd1;
	localparam logic [2:0] REQ_START      = 3'd2;
	localparam logic [2:0] REQ_WRITE      = 3'd3;
	localparam logic [2:0] REQ_READ       = 3'd4;
	localparam logic [2:0] REQ_SOFT_RESET = 3'd5;

	localparam logic [2:0] REG_RESET_LOW   = 3'd0;
	localparam logic [2:0] REG_STOP_LOW    = 3'd1;
	localparam logic [2:0] REG_STOP_HIGH   = 3'd2;
	localparam logic [2:0] REG_READ_SAMPLE = 3'd3;
	localparam logic [2:0] REG_READ_REST   = 3'd4;
	localparam logic [2:0] REG_WRITE_ZERO  = 3'd5;
	localparam logic [2:0] REG_WRITE_ONE   = 3'd6;
	localparam logic [2:0] REG_BIT_SLOT    = 3'd7;

	typedef enum logic [1:0] {
		DRV_LOW  = 2'd0,
		DRV_HIGH = 2'd1,
		DRV_REL  = 2'd2
	} drive_t;

	typedef struct packed {
		logic [15:0] reset_low_ticks;
		logic [15:0] stop_low_ticks;
		logic [15:0] stop_high_ticks;
		logic [15:0] read_sample_ticks;
		logic [15:0] read_rest_ticks;
		logic [15:0] write_zero_low_ticks;
		logic [15:0] write_one_low_ticks;
		logic [15:0] bit_slot_ticks;
	} cfg_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] tx_byte;
		logic       end_flag;
		logic       line_level;
	} item_t;

	typedef struct packed {
		drive_t     line_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       nack;
	} res_t;

endpackage

// File: design/swbm_cfg_regs.sv
module swbm_cfg_regs import swbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t        cfg_q;
	logic [2:0]  idx;
	logic        wr_en;
	logic [15:0] rd_val;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_RESET_LOW:   cfg_q.reset_low_ticks      <= pwdata[15:0];
				REG_STOP_LOW:    cfg_q.stop_low_ticks       <= pwdata[15:0];
				REG_STOP_HIGH:   cfg_q.stop_high_ticks      <= pwdata[15:0];
				REG_READ_SAMPLE: cfg_q.read_sample_ticks    <= pwdata[15:0];
				REG_READ_REST:   cfg_q.read_rest_ticks      <= pwdata[15:0];
				REG_WRITE_ZERO:  cfg_q.write_zero_low_ticks <= pwdata[15:0];
				REG_WRITE_ONE:   cfg_q.write_one_low_ticks  <= pwdata[15:0];
				REG_BIT_SLOT:    cfg_q.bit_slot_ticks       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RESET_LOW:   rd_val = cfg_q.reset_low_ticks;
			REG_STOP_LOW:    rd_val = cfg_q.stop_low_ticks;
			REG_STOP_HIGH:   rd_val = cfg_q.stop_high_ticks;
			REG_READ_SAMPLE: rd_val = cfg_q.read_sample_ticks;
			REG_READ_REST:   rd_val = cfg_q.read_rest_ticks;
			REG_WRITE_ZERO:  rd_val = cfg_q.write_zero_low_ticks;
			REG_WRITE_ONE:   rd_val = cfg_q.write_one_low_ticks;
			REG_BIT_SLOT:    rd_val = cfg_q.bit_slot_ticks;
			default:         rd_val = '0;
		endcase
	end

	assign prdata = {16'd0, rd_val};

endmodule

// File: design/swbm_seq.sv
module swbm_seq import swbm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  go,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_RST_LOW   = 4'd1,
		PH_SR_HIGH1  = 4'd2,
		PH_SR_LOW    = 4'd3,
		PH_SR_HIGH2  = 4'd4,
		PH_STOP_LOW  = 4'd5,
		PH_STOP_HIGH = 4'd6,
		PH_WB_LOW    = 4'd7,
		PH_WB_HIGH   = 4'd8,
		PH_RB_LOW    = 4'd9,
		PH_RB_SAMPLE = 4'd10,
		PH_RB_REST   = 4'd11
	} phase_t;

	// pending zero-length phase still to be resolved in this tick
	typedef enum logic [2:0] {
		ENT_NONE,
		ENT_RBREST,
		ENT_STOP,
		ENT_STOPHIGH,
		ENT_WBHIGH,
		ENT_WBDONE,
		ENT_WB,
		ENT_RBLOW
	} ent_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] cnt;
		drive_t      drv;
		ent_t        ent;
		logic        done;
	} seq_t;

	localparam logic [3:0] BI_START = 4'd9;
	localparam logic [3:0] BI_BYTE  = 4'd8;

	// cnt_q holds the ticks left including the current one
	phase_t      phase_q;
	logic [15:0] cnt_q;
	logic [3:0]  bi_q;
	logic [7:0]  shift_q;
	logic [2:0]  op_q;
	logic        end_q;
	logic        nack_q;
	drive_t      drive_q;
	logic [7:0]  rx_q;

	seq_t        s;
	logic [3:0]  n_bi;
	logic [7:0]  n_shift;
	logic [2:0]  n_op;
	logic        n_end;
	logic        n_nack;
	logic [7:0]  n_rx;
	logic        is_rd;
	logic        wbit;
	logic        found;
	logic [3:0]  fj;

	logic        zero0, zero1;
	logic [15:0] high0, high1;

	assign zero0 = (cfg.write_zero_low_ticks == '0) && (cfg.bit_slot_ticks == '0);
	assign zero1 = (cfg.write_one_low_ticks == '0) && (cfg.bit_slot_ticks == '0);
	assign high0 = (cfg.bit_slot_ticks > cfg.write_zero_low_ticks) ?
		cfg.bit_slot_ticks - cfg.write_zero_low_ticks : '0;
	assign high1 = (cfg.bit_slot_ticks > cfg.write_one_low_ticks) ?
		cfg.bit_slot_ticks - cfg.write_one_low_ticks : '0;

	function automatic logic bit_at(logic [3:0] idx, logic [7:0] sh);
		logic [2:0] pos;
		pos = 3'(idx - 4'd1);
		if (idx == BI_START || idx == 4'd0) return 1'b0;
		return sh[pos];
	endfunction

	function automatic seq_t rest(seq_t r, phase_t p, logic [15:0] c, drive_t d);
		seq_t o;
		o       = r;
		o.phase = p;
		o.cnt   = c;
		o.drv   = d;
		o.ent   = ENT_NONE;
		return o;
	endfunction

	function automatic seq_t to_idle(seq_t r);
		seq_t o;
		o       = r;
		o.phase = PH_IDLE;
		o.ent   = ENT_NONE;
		o.done  = 1'b1;
		return o;
	endfunction

	function automatic seq_t stop_stage(seq_t r, cfg_t c, logic [3:0] bi);
		seq_t o;
		o = r;
		if (o.ent == ENT_STOP) begin
			if (c.stop_low_ticks != '0) o = rest(o, PH_STOP_LOW, c.stop_low_ticks, DRV_LOW);
			else o.ent = ENT_STOPHIGH;
		end
		if (o.ent == ENT_STOPHIGH) begin
			o.drv = DRV_HIGH;
			if (c.stop_high_ticks != '0) o = rest(o, PH_STOP_HIGH, c.stop_high_ticks, DRV_HIGH);
			else if (bi != '0) o.ent = ENT_WB;
			else o = to_idle(o);
		end
		return o;
	endfunction

	always_comb begin
		s.phase = phase_q;
		s.cnt   = cnt_q;
		s.drv   = drive_q;
		s.ent   = ENT_NONE;
		s.done  = 1'b0;
		n_bi    = bi_q;
		n_shift = shift_q;
		n_op    = op_q;
		n_end   = end_q;
		n_nack  = nack_q;
		n_rx    = rx_q;
		wbit    = 1'b0;
		found   = 1'b0;
		fj      = '0;

		if (phase_q == PH_IDLE) begin
			unique case (item.req_type)
				REQ_BUS_RESET: begin
					n_op  = item.req_type;
					n_end = item.end_flag;
					if (cfg.reset_low_ticks != '0) begin
						s = rest(s, PH_RST_LOW, cfg.reset_low_ticks, DRV_LOW);
					end else begin
						s.drv = DRV_HIGH;
						s     = to_idle(s);
					end
				end
				REQ_START: begin
					n_op    = item.req_type;
					n_end   = item.end_flag;
					n_bi    = BI_START;
					n_shift = item.tx_byte;
					s.ent   = ENT_STOP;
				end
				REQ_WRITE: begin
					n_op    = item.req_type;
					n_end   = item.end_flag;
					n_bi    = BI_BYTE;
					n_shift = item.tx_byte;
					s.ent   = ENT_WB;
				end
				REQ_READ: begin
					n_op  = item.req_type;
					n_end = item.end_flag;
					n_bi  = BI_BYTE;
					n_rx  = '0;
					s.ent = ENT_RBLOW;
				end
				REQ_SOFT_RESET: begin
					n_op  = item.req_type;
					n_end = item.end_flag;
					s     = rest(s, PH_SR_HIGH1, SR_HALF_TICKS, DRV_HIGH);
				end
				default: ;
			endcase
		end else if (cnt_q != 16'd1) begin
			s.cnt = cnt_q - 16'd1;
		end else begin
			unique case (phase_q)
				PH_RST_LOW: begin
					s.drv = DRV_HIGH;
					s     = to_idle(s);
				end
				PH_SR_HIGH1:  s = rest(s, PH_SR_LOW, SR_FULL_TICKS, DRV_LOW);
				PH_SR_LOW:    s = rest(s, PH_SR_HIGH2, SR_HALF_TICKS, DRV_HIGH);
				PH_STOP_LOW:  s.ent = ENT_STOPHIGH;
				PH_STOP_HIGH: begin
					if (bi_q != '0) s.ent = ENT_WB;
					else s = to_idle(s);
				end
				PH_WB_LOW:    s.ent = ENT_WBHIGH;
				PH_WB_HIGH:   s.ent = ENT_WBDONE;
				PH_RB_LOW:    s = rest(s, PH_RB_SAMPLE, 16'd1, DRV_REL);
				PH_RB_SAMPLE: s.ent = ENT_RBREST;
				PH_RB_REST:   begin
					s.drv = DRV_REL;
					s.ent = ENT_RBREST;
				end
				default:      s = to_idle(s);
			endcase
			// a real RB_REST expiry must not restart the rest phase
			if (phase_q == PH_RB_REST) begin
				if (op_q == REQ_READ) begin
					if (n_bi != '0) n_bi = n_bi - 4'd1;
					s.ent = (n_bi != '0) ? ENT_RBLOW : ENT_WB;
				end else if (nack_q || (op_q == REQ_WRITE && end_q)) begin
					s.ent = ENT_STOP;
				end else begin
					s = to_idle(s);
				end
			end
		end

		is_rd = (n_op == REQ_READ);

		if (s.ent == ENT_RBREST) begin
			s.drv = DRV_REL;
			if (cfg.read_rest_ticks != '0) begin
				s = rest(s, PH_RB_REST, cfg.read_rest_ticks, DRV_REL);
			end else if (is_rd) begin
				if (n_bi != '0) n_bi = n_bi - 4'd1;
				s.ent = (n_bi != '0) ? ENT_RBLOW : ENT_WB;
			end else if (n_nack || (n_op == REQ_WRITE && n_end)) begin
				s.ent = ENT_STOP;
			end else begin
				s = to_idle(s);
			end
		end

		s = stop_stage(s, cfg, n_bi);

		if (s.ent == ENT_WBHIGH) begin
			wbit  = is_rd ? n_end : bit_at(n_bi, n_shift);
			s.drv = DRV_HIGH;
			if ((wbit ? high1 : high0) != '0) s = rest(s, PH_WB_HIGH, wbit ? high1 : high0, DRV_HIGH);
			else s.ent = ENT_WBDONE;
		end

		if (s.ent == ENT_WBDONE) begin
			if (is_rd) begin
				if (n_end) s.ent = ENT_STOP;
				else s = to_idle(s);
			end else begin
				if (n_bi != '0) n_bi = n_bi - 4'd1;
				s.ent = (n_bi != '0) ? ENT_WB : ENT_RBLOW;
			end
		end

		if (s.ent == ENT_WB) begin
			if (is_rd) begin
				wbit = n_end;
				if (!(wbit ? zero1 : zero0)) begin
					if ((wbit ? cfg.write_one_low_ticks : cfg.write_zero_low_ticks) != '0)
						s = rest(s, PH_WB_LOW,
							wbit ? cfg.write_one_low_ticks : cfg.write_zero_low_ticks, DRV_LOW);
					else
						s = rest(s, PH_WB_HIGH, wbit ? high1 : high0, DRV_HIGH);
				end else begin
					s.drv = DRV_HIGH;
					if (n_end) s.ent = ENT_STOP;
					else s = to_idle(s);
				end
			end else begin
				for (int j = 1; j <= 9; j++) begin
					if (4'(j) <= n_bi && !(bit_at(4'(j), n_shift) ? zero1 : zero0)) begin
						found = 1'b1;
						fj    = 4'(j);
					end
				end
				if (found) begin
					n_bi = fj;
					wbit = bit_at(fj, n_shift);
					if ((wbit ? cfg.write_one_low_ticks : cfg.write_zero_low_ticks) != '0)
						s = rest(s, PH_WB_LOW,
							wbit ? cfg.write_one_low_ticks : cfg.write_zero_low_ticks, DRV_LOW);
					else
						s = rest(s, PH_WB_HIGH, wbit ? high1 : high0, DRV_HIGH);
				end else begin
					n_bi  = '0;
					s.drv = DRV_HIGH;
					s.ent = ENT_RBLOW;
				end
			end
		end

		s = stop_stage(s, cfg, n_bi);

		if (s.ent == ENT_RBLOW) begin
			if (cfg.read_sample_ticks != '0)
				s = rest(s, PH_RB_LOW, cfg.read_sample_ticks, DRV_LOW);
			else
				s = rest(s, PH_RB_SAMPLE, 16'd1, DRV_REL);
		end

		if (s.phase == PH_RB_SAMPLE) begin
			if (is_rd) n_rx = {n_rx[6:0], item.line_level};
			else n_nack = item.line_level;
		end
	end

	assign res.line_drive = s.drv;
	assign res.busy_res   = (s.phase != PH_IDLE);
	assign res.done_res   = s.done;
	assign res.rx_byte    = n_rx;
	assign res.nack       = n_nack;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			bi_q    <= '0;
			shift_q <= '0;
			op_q    <= REQ_NONE;
			end_q   <= 1'b0;
			nack_q  <= 1'b0;
			drive_q <= DRV_REL;
			rx_q    <= '0;
		end else if (go) begin
			phase_q <= s.phase;
			cnt_q   <= s.cnt;
			bi_q    <= n_bi;
			shift_q <= n_shift;
			op_q    <= n_op;
			end_q   <= n_end;
			nack_q  <= n_nack;
			drive_q <= s.drv;
			rx_q    <= n_rx;
		end
	end

endmodule

// File: design/single_wire_bus_master.sv
// A word's result is registered in the result stage when that stage is free.
// Throughput: one word per cycle unless out_ready stalls; the bus sequencer
// settles all phases, zero-length chains too, combinationally between the stages.
// Reset (arst_n low, asynchronous): sequencer idle, line released, read byte and
// nack cleared, all timing registers zero, both word stages empty.
module single_wire_bus_master import swbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [7:0]  tx_byte,
	input  logic        end_flag,
	input  logic        line_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  line_drive,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  rx_byte,
	output logic        nack
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_s2;
	logic  valid_s2;
	logic  go;

	swbm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	assign go       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.req_type   <= req_type;
			item_s1.tx_byte    <= tx_byte;
			item_s1.end_flag   <= end_flag;
			item_s1.line_level <= line_level;
		end
	end

	swbm_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (go),
		.item  (item_s1),
		.cfg   (cfg),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign line_drive = res_s2.line_drive;
	assign busy_res   = res_s2.busy_res;
	assign done_res   = res_s2.done_res;
	assign rx_byte    = res_s2.rx_byte;
	assign nack       = res_s2.nack;

	// a finished command never reports busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.done_res && res_s2.busy_res))
		else $error("done and busy together");

	// every sequence ends with the line high or released
	a_done_not_low: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.done_res) |-> (res_s2.line_drive != DRV_LOW))
		else $error("command completed with line driven low");

	// a held result word is not overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> (valid_s2 && $stable(res_s2)))
		else $error("stalled result word changed");

	// no word is taken while both stages are full and stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |-> !in_ready)
		else $error("input taken while pipeline stalled");

endmodule

// File: dv/single_wire_bus_master_test.sv
module single_wire_bus_master_test;
	timeunit 1ns;
	timeprecision 1ps;
	import swbm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_RST_LOW, S_SR_HIGH1, S_SR_LOW, S_SR_HIGH2, S_STOP_LOW, S_STOP_HIGH,
		S_BIT_LOW, S_BIT_HIGH, S_RD_LOW, S_RD_SAMPLE, S_RD_REST
	} seq_phase_t;

	class line_scoreboard;
		cfg_t cfg;
		seq_phase_t ph;
		logic [15:0] ticks_left;
		logic [3:0] bit_idx;
		logic [7:0] tx_shift;
		logic [7:0] rx_acc;
		logic [2:0] cmd;
		logic end_lat;
		logic nack_lat;
		drive_t drv;
		res_t due_results[$];
		int errors;
		int words_in;
		int words_checked;
		int cmds_started;

		function new();
			cfg = '0;
			ph = S_IDLE;
			ticks_left = '0;
			bit_idx = '0;
			tx_shift = '0;
			rx_acc = '0;
			cmd = '0;
			end_lat = 1'b0;
			nack_lat = 1'b0;
			drv = DRV_REL;
			errors = 0;
			words_in = 0;
			words_checked = 0;
			cmds_started = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_RESET_LOW:   cfg.reset_low_ticks = val;
				REG_STOP_LOW:    cfg.stop_low_ticks = val;
				REG_STOP_HIGH:   cfg.stop_high_ticks = val;
				REG_READ_SAMPLE: cfg.read_sample_ticks = val;
				REG_READ_REST:   cfg.read_rest_ticks = val;
				REG_WRITE_ZERO:  cfg.write_zero_low_ticks = val;
				REG_WRITE_ONE:   cfg.write_one_low_ticks = val;
				default:         cfg.bit_slot_ticks = val;
			endcase
		endfunction

		// read byte sends its end flag as the ack bit; start bit is always 0
		function logic send_bit();
			if (cmd == REQ_READ)
				return end_lat;
			if (bit_idx == 4'd9 || bit_idx == 4'd0)
				return 1'b0;
			return tx_shift[3'(bit_idx - 4'd1)];
		endfunction

		function logic [15:0] low_len();
			return send_bit() ? cfg.write_one_low_ticks : cfg.write_zero_low_ticks;
		endfunction

		function void go(seq_phase_t p);
			logic [15:0] lo;
			ph = p;
			case (p)
				S_RST_LOW: begin
					drv = DRV_LOW;
					ticks_left = cfg.reset_low_ticks;
				end
				S_SR_HIGH1, S_SR_HIGH2: begin
					drv = DRV_HIGH;
					ticks_left = SR_HALF_TICKS;
				end
				S_SR_LOW: begin
					drv = DRV_LOW;
					ticks_left = SR_FULL_TICKS;
				end
				S_STOP_LOW: begin
					drv = DRV_LOW;
					ticks_left = cfg.stop_low_ticks;
				end
				S_STOP_HIGH: begin
					drv = DRV_HIGH;
					ticks_left = cfg.stop_high_ticks;
				end
				S_BIT_LOW: begin
					drv = DRV_LOW;
					ticks_left = low_len();
				end
				S_BIT_HIGH: begin
					lo = low_len();
					drv = DRV_HIGH;
					ticks_left = (cfg.bit_slot_ticks > lo) ? cfg.bit_slot_ticks - lo : 16'd0;
				end
				S_RD_LOW: begin
					drv = DRV_LOW;
					ticks_left = cfg.read_sample_ticks;
				end
				S_RD_SAMPLE: begin
					drv = DRV_REL;
					ticks_left = 16'd1;
				end
				S_RD_REST: begin
					drv = DRV_REL;
					ticks_left = cfg.read_rest_ticks;
				end
				default: begin
					ph = S_IDLE;
					ticks_left = '0;
				end
			endcase
		endfunction

		function void step_phase();
			case (ph)
				S_RST_LOW: begin
					drv = DRV_HIGH;
					go(S_IDLE);
				end
				S_SR_HIGH1: go(S_SR_LOW);
				S_SR_LOW: go(S_SR_HIGH2);
				S_STOP_LOW: go(S_STOP_HIGH);
				S_STOP_HIGH: begin
					if (bit_idx != 0)
						go(S_BIT_LOW);
					else
						go(S_IDLE);
				end
				S_BIT_LOW: go(S_BIT_HIGH);
				S_BIT_HIGH: begin
					if (cmd == REQ_READ) begin
						if (end_lat)
							go(S_STOP_LOW);
						else
							go(S_IDLE);
					end else begin
						if (bit_idx != 0)
							bit_idx--;
						if (bit_idx != 0)
							go(S_BIT_LOW);
						else
							go(S_RD_LOW);
					end
				end
				S_RD_LOW: go(S_RD_SAMPLE);
				S_RD_SAMPLE: go(S_RD_REST);
				S_RD_REST: begin
					if (cmd == REQ_READ) begin
						if (bit_idx != 0)
							bit_idx--;
						if (bit_idx != 0)
							go(S_RD_LOW);
						else
							go(S_BIT_LOW);
					end else if (nack_lat || (cmd == REQ_WRITE && end_lat)) begin
						go(S_STOP_LOW);
					end else begin
						go(S_IDLE);
					end
				end
				default: go(S_IDLE);
			endcase
		endfunction

		function void note_tick(item_t w);
			logic fin;
			res_t r;
			fin = 1'b0;
			words_in++;
			if (ph == S_IDLE && w.req_type >= REQ_BUS_RESET && w.req_type <= REQ_SOFT_RESET) begin
				cmd = w.req_type;
				end_lat = w.end_flag;
				cmds_started++;
				case (w.req_type)
					REQ_BUS_RESET: go(S_RST_LOW);
					REQ_START: begin
						bit_idx = 4'd9;
						tx_shift = w.tx_byte;
						go(S_STOP_LOW);
					end
					REQ_WRITE: begin
						bit_idx = 4'd8;
						tx_shift = w.tx_byte;
						go(S_BIT_LOW);
					end
					REQ_READ: begin
						bit_idx = 4'd8;
						rx_acc = '0;
						go(S_RD_LOW);
					end
					default: go(S_SR_HIGH1);
				endcase
				if (ph == S_IDLE)
					fin = 1'b1;
			end
			if (ph != S_IDLE) begin
				// empty phases fall through within the tick
				while (ph != S_IDLE && ticks_left == 0)
					step_phase();
				if (ph == S_IDLE) begin
					fin = 1'b1;
				end else begin
					if (ph == S_RD_SAMPLE) begin
						if (cmd == REQ_READ)
							rx_acc = {rx_acc[6:0], w.line_level};
						else
							nack_lat = w.line_level;
					end
					ticks_left--;
				end
			end
			r.line_drive = drv;
			r.busy_res = (ph != S_IDLE);
			r.done_res = fin;
			r.rx_byte = rx_acc;
			r.nack = nack_lat;
			due_results.push_back(r);
		endfunction

		task report_mismatch(string what);
			if (errors < 100)
				$display("MISMATCH @%0t: %s", $realtime, what);
			errors++;
		endtask

		task check_word(res_t got);
			res_t exp;
			if (due_results.size() == 0) begin
				report_mismatch("result word with nothing expected");
				return;
			end
			exp = due_results.pop_front();
			words_checked++;
			if (got.line_drive !== exp.line_drive)
				report_mismatch($sformatf("word %0d line_drive %0d, expected %0d",
					words_checked, got.line_drive, exp.line_drive));
			if (got.busy_res !== exp.busy_res)
				report_mismatch($sformatf("word %0d busy_res %b, expected %b",
					words_checked, got.busy_res, exp.busy_res));
			if (got.done_res !== exp.done_res)
				report_mismatch($sformatf("word %0d done_res %b, expected %b",
					words_checked, got.done_res, exp.done_res));
			if (got.rx_byte !== exp.rx_byte)
				report_mismatch($sformatf("word %0d rx_byte %h, expected %h",
					words_checked, got.rx_byte, exp.rx_byte));
			if (got.nack !== exp.nack)
				report_mismatch($sformatf("word %0d nack %b, expected %b",
					words_checked, got.nack, exp.nack));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] req_type = REQ_NONE;
	logic [7:0] tx_byte = '0;
	logic end_flag = 1'b0;
	logic line_level = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] line_drive;
	logic busy_res;
	logic done_res;
	logic [7:0] rx_byte;
	logic nack;

	line_scoreboard sb = new();
	int burst_left = 0;
	int stall_left = 0;
	logic [1:0] stall_mode = '0;
	int settings_run = 0;
	logic [15:0] cfg_vals[8];

	single_wire_bus_master uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.tx_byte(tx_byte),
		.end_flag(end_flag),
		.line_level(line_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.line_drive(line_drive),
		.busy_res(busy_res),
		.done_res(done_res),
		.rx_byte(rx_byte),
		.nack(nack)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: free-running, random or periodic stalls, switching now and then
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= 2'($urandom_range(0, 3));
			stall_left <= $urandom_range(32, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= ($urandom_range(0, 1) != 0);
			2'd2: out_ready <= (stall_left[2:0] != 3'd0);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word(res_t'{drive_t'(line_drive), busy_res, done_res, rx_byte, nack});
	end

	task automatic push_word(input item_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = $urandom_range(0, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		{req_type, tx_byte, end_flag, line_level} <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_tick(w);
	endtask

	task automatic tick_word(input logic [2:0] req);
		item_t w;
		w.req_type = req;
		w.tx_byte = 8'($urandom);
		w.end_flag = 1'($urandom);
		w.line_level = 1'($urandom);
		push_word(w);
	endtask

	// plain ticks, now and then a command the busy block must ignore
	task automatic run_to_idle();
		while (sb.ph != S_IDLE) begin
			if ($urandom_range(0, 7) == 0)
				tick_word(3'($urandom));
			else
				tick_word(REQ_NONE);
		end
	endtask

	task automatic run_cmd(input logic [2:0] req, input logic [7:0] tx, input logic endf);
		item_t w;
		w.req_type = req;
		w.tx_byte = tx;
		w.end_flag = endf;
		w.line_level = 1'($urandom);
		push_word(w);
		run_to_idle();
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
	endtask

	task automatic program_regs();
		for (int i = 0; i < 8; i++)
			apb_write(3'(i), cfg_vals[i]);
		psel <= 1'b0;
		penable <= 1'b0;
		settings_run++;
	endtask

	task automatic pick_small_config();
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(0, 9))
				0: cfg_vals[i] = 16'd0;
				1: cfg_vals[i] = 16'($urandom_range(5, 12));
				default: cfg_vals[i] = 16'($urandom_range(1, 3));
			endcase
		end
	endtask

	function automatic logic [2:0] pick_cmd();
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5: return REQ_WRITE;
			6, 7, 8, 9, 10: return REQ_READ;
			11, 12, 13, 14: return REQ_START;
			15, 16: return REQ_BUS_RESET;
			17: return REQ_SOFT_RESET;
			18: return REQ_NONE;
			default: return 3'($urandom_range(6, 7));
		endcase
	endfunction

	task automatic random_words(input int want);
		int counted;
		item_t w;
		counted = 0;
		while (counted < want) begin
			w.tx_byte = 8'($urandom);
			w.end_flag = 1'($urandom);
			w.line_level = 1'($urandom);
			if (sb.ph == S_IDLE)
				w.req_type = pick_cmd();
			else if ($urandom_range(0, 9) == 0)
				w.req_type = 3'($urandom);
			else
				w.req_type = REQ_NONE;
			if (sb.ph == S_IDLE || w.req_type == REQ_NONE)
				counted++;
			push_word(w);
		end
		run_to_idle();
	endtask

	task automatic directed_set();
		run_cmd(REQ_BUS_RESET, 8'h00, 1'b0);
		run_cmd(REQ_START, 8'hFF, 1'b0);
		run_cmd(REQ_START, 8'h00, 1'b1);
		run_cmd(REQ_WRITE, 8'h00, 1'b1);
		run_cmd(REQ_WRITE, 8'hFF, 1'b0);
		run_cmd(REQ_WRITE, 8'hA5, 1'b1);
		run_cmd(REQ_READ, 8'h5A, 1'b1);
		run_cmd(REQ_READ, 8'h00, 1'b0);
		run_cmd(REQ_SOFT_RESET, 8'h00, 1'b0);
		tick_word(REQ_NONE);
		tick_word(3'd6);
		tick_word(3'd7);
	endtask

	initial begin
		int guard;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all timing zero straight out of reset
		directed_set();
		settle();
		// short slots with the write-one low time longer than the slot
		cfg_vals = '{16'd2, 16'd1, 16'd2, 16'd1, 16'd2, 16'd1, 16'd4, 16'd3};
		program_regs();
		directed_set();

		for (int p = 0; p < 10; p++) begin
			settle();
			pick_small_config();
			program_regs();
			random_words(130);
		end

		in_valid <= 1'b0;
		guard = 0;
		while (sb.due_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
		if (sb.due_results.size() != 0)
			sb.report_mismatch($sformatf("%0d result words never arrived",
				sb.due_results.size()));
		$display("ran %0d ticks, %0d commands, checked %0d result words",
			sb.words_in, sb.cmds_started, sb.words_checked);
		$display("timing settings: %0d, incl. all-zero after reset", settings_run + 1);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end

endmodule
